// ===== rtl/core/dep_pkg.sv =====
// Shared types and constants for the double-ended priority queue.
package dep_pkg;

    // Store depth and value width
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    // Operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_INSERT  = 2'd0;
    localparam t_op OP_DEL_MAX = 2'd1;
    localparam t_op OP_DEL_MIN = 2'd2;
    localparam t_op OP_CLEAR   = 2'd3;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // Command from the input register to the cell array
    typedef struct packed {
        logic   load;
        t_op    op;
        t_value value;
    } t_cmd;

    // Status from the cell array to the output stage
    typedef struct packed {
        logic done;
        logic dropped;
    } t_sts;

endpackage

// ===== rtl/core/dep_cell_array.sv =====
// Sorted register array: all cells compare and shift in parallel, one operation per cycle while i_adv is high.
module dep_cell_array (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  dep_pkg::t_cmd                       i_cmd,
    output dep_pkg::t_value                     o_cells [dep_pkg::CAPACITY],
    output logic [dep_pkg::CAPACITY-1:0]        o_valid,
    output dep_pkg::t_sts                       o_sts
);

    dep_pkg::t_value                 r_cells [dep_pkg::CAPACITY];
    dep_pkg::t_value                 n_cells [dep_pkg::CAPACITY];
    logic [dep_pkg::CAPACITY-1:0]    r_valid;
    logic [dep_pkg::CAPACITY-1:0]    n_valid;
    logic [dep_pkg::CAPACITY-1:0]    gt;
    logic                            full;
    logic                            r_done;
    logic                            r_dropped;
    dep_pkg::t_sts                   n_sts;

    // Compare every occupied cell against the incoming value
    always_comb begin
        for (int i = 0; i < dep_pkg::CAPACITY; i++) begin
            gt[i] = r_valid[i] && (r_cells[i] > i_cmd.value);
        end
        full = r_valid[dep_pkg::CAPACITY-1];
    end

    // Work out the next store contents; occupancy is a thermometer from cell 0
    always_comb begin
        n_cells     = r_cells;
        n_valid     = r_valid;
        n_sts.done    = i_cmd.load;
        n_sts.dropped = 1'b0;
        if (i_cmd.load) begin
            unique case (i_cmd.op)
                dep_pkg::OP_INSERT: begin
                    if (full) begin
                        n_sts.dropped = 1'b1;
                    end else begin
                        // shift larger values up, drop the new one in behind equal ones
                        if (gt[0] || !r_valid[0]) begin
                            n_cells[0] = i_cmd.value;
                        end
                        for (int i = 1; i < dep_pkg::CAPACITY; i++) begin
                            if (gt[i-1]) begin
                                n_cells[i] = r_cells[i-1];
                            end else if (gt[i] || !r_valid[i]) begin
                                n_cells[i] = i_cmd.value;
                            end
                        end
                        n_valid = {r_valid[dep_pkg::CAPACITY-2:0], 1'b1};
                    end
                end
                dep_pkg::OP_DEL_MAX: begin
                    // drop the top occupied cell
                    n_valid = {1'b0, r_valid[dep_pkg::CAPACITY-1:1]};
                end
                dep_pkg::OP_DEL_MIN: begin
                    // advance every cell down by one
                    for (int i = 0; i < dep_pkg::CAPACITY - 1; i++) begin
                        n_cells[i] = r_cells[i+1];
                    end
                    n_valid = {1'b0, r_valid[dep_pkg::CAPACITY-1:1]};
                end
                dep_pkg::OP_CLEAR: begin
                    n_valid = '0;
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    // Hold the cell payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_cells   <= n_cells;
            r_dropped <= n_sts.dropped;
        end
    end

    // Hold occupancy and the completion flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_done  <= n_sts.done;
        end
    end

    assign o_cells = r_cells;
    assign o_valid = r_valid;
    assign o_sts   = '{done: r_done, dropped: r_dropped};

endmodule

// ===== rtl/core/dep_out_select.sv =====
// Output stage: picks maximum and minimum from the sorted cells into the result register.
module dep_out_select (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  dep_pkg::t_value                     i_cells [dep_pkg::CAPACITY],
    input  logic [dep_pkg::CAPACITY-1:0]        i_valid,
    input  dep_pkg::t_sts                       i_sts,
    output logic                                o_out_valid,
    output dep_pkg::t_value                     o_max_value,
    output dep_pkg::t_value                     o_min_value,
    output logic                                o_is_empty,
    output logic                                o_insert_dropped
);

    logic [dep_pkg::CAPACITY-1:0] last;
    dep_pkg::t_value              max_sel;
    dep_pkg::t_value              min_sel;
    logic                         r_out_valid;
    dep_pkg::t_value              r_max;
    dep_pkg::t_value              r_min;
    logic                         r_empty;
    logic                         r_dropped;

    // Mark the top occupied cell and select it with an and-or
    always_comb begin
        last    = i_valid & ~{1'b0, i_valid[dep_pkg::CAPACITY-1:1]};
        max_sel = '0;
        for (int i = 0; i < dep_pkg::CAPACITY; i++) begin
            max_sel = max_sel | (i_cells[i] & {dep_pkg::VALUE_WIDTH{last[i]}});
        end
        min_sel = i_valid[0] ? i_cells[0] : '0;
    end

    // Capture the result payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_max     <= max_sel;
            r_min     <= min_sel;
            r_empty   <= !i_valid[0];
            r_dropped <= i_sts.dropped;
        end
    end

    // Hold the result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_sts.done;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_max_value      = r_max;
    assign o_min_value      = r_min;
    assign o_is_empty       = r_empty;
    assign o_insert_dropped = r_dropped;

endmodule

// ===== rtl/core/double_ended_priority_queue.sv =====
// A transaction passes through the input register, the cell array registers and the result register in turn.
// Throughput: one transaction per cycle; the sorted cell array compares and shifts
// all cells at once, and the whole pipeline stalls together while a result is held.
// Reset (synchronous, active low) empties the queue and clears the valid flags;
// cell contents are not cleared and are never read before they are written.
module double_ended_priority_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dep_pkg::t_op         i_operation,
    input  dep_pkg::t_value      i_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output dep_pkg::t_value      o_max_value,
    output dep_pkg::t_value      o_min_value,
    output logic                 o_is_empty,
    output logic                 o_insert_dropped
);

    logic                          adv;
    logic                          r_in_valid;
    dep_pkg::t_op                  r_op;
    dep_pkg::t_value               r_value;
    dep_pkg::t_cmd                 cmd;
    dep_pkg::t_value               cells [dep_pkg::CAPACITY];
    logic [dep_pkg::CAPACITY-1:0]  valid;
    dep_pkg::t_sts                 sts;

    // Advance the pipeline whenever the result register is free or being taken
    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (adv && i_in_valid) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
    end

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_comb begin
        cmd.load  = r_in_valid;
        cmd.op    = r_op;
        cmd.value = r_value;
    end

    dep_cell_array u_cells (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_cmd   (cmd),
        .o_cells (cells),
        .o_valid (valid),
        .o_sts   (sts)
    );

    dep_out_select u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_cells          (cells),
        .i_valid          (valid),
        .i_sts            (sts),
        .o_out_valid      (o_out_valid),
        .o_max_value      (o_max_value),
        .o_min_value      (o_min_value),
        .o_is_empty       (o_is_empty),
        .o_insert_dropped (o_insert_dropped)
    );

`ifndef SYNTH
    // Occupied cells always form a contiguous run starting at cell 0
    a_valid_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid + 1'b1) & valid) == '0)
        else $error("occupancy is not contiguous");

    // A refused insert only happens on a full, hence non-empty, queue
    a_drop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_insert_dropped) |-> !o_is_empty)
        else $error("insert dropped on an empty queue");

    // Reported maximum never lies below the reported minimum
    a_max_ge_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_is_empty) |-> (o_max_value >= o_min_value))
        else $error("maximum below minimum");

    // An empty queue reports zero for both extremes
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> (o_max_value == '0 && o_min_value == '0))
        else $error("empty queue reports nonzero extremes");
`endif

endmodule
